/* hdl/srca_pkg.sv */
// Shared types for the stage release chunk allocator.
// No dependencies; used by the top level and its port checker.
package srca_pkg;

	// item opcode
	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_MARK  = 1'b1
	} op_t;

	// width of the slot index field on the ports
	localparam int SLOT_FIELD_W = 6;

endpackage

/* hdl/srca_ram.sv */
// Simple dual-port synchronous RAM: one write port, one read port.
// Read data is registered. No package dependency.
module srca_ram #(
	parameter int ADDR_W = 6,
	parameter int DATA_W = 64
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [(1 << ADDR_W)];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hdl/srca_search.sv */
// Rotated first-free search over one worker's busy vector.
// Combinational; no package dependency.
module srca_search #(
	parameter int POOL_SLOTS = 64
) (
	input  logic [POOL_SLOTS-1:0]         busy,
	input  logic [$clog2(POOL_SLOTS)-1:0] start,
	output logic                          hit,
	output logic [$clog2(POOL_SLOTS)-1:0] idx,
	output logic [$clog2(POOL_SLOTS)-1:0] idx_next
);

	localparam int SW = $clog2(POOL_SLOTS);

	typedef logic [POOL_SLOTS-1:0] vec_t;

	logic [SW-1:0] start_c;
	vec_t          free;
	vec_t          upper;
	vec_t          pick;
	vec_t          lowest;

	always_comb begin
		// stale pointer beyond the ring restarts at slot 0
		start_c = (32'(start) < POOL_SLOTS) ? start : '0;
		free    = ~busy;
		upper   = free & ({POOL_SLOTS{1'b1}} << start_c);
		pick    = (|upper) ? upper : free;
		lowest  = pick & (~pick + vec_t'(1));
		hit     = |free;
		idx     = '0;
		for (int i = 0; i < POOL_SLOTS; i++) begin
			if (lowest[i]) begin
				idx = idx | SW'(i);
			end
		end
	end

	assign idx_next = (32'(idx) == POOL_SLOTS - 1) ? '0 : idx + SW'(1);

endmodule

/* hdl/stage_release_chunk_allocator.sv */
// Stage release chunk allocator, top level.
// Uses srca_pkg, srca_ram (mask store and ring store) and srca_search.
//
// Each worker owns a ring of POOL_SLOTS chunk slots; every slot holds a mask of the
// pipeline stages that still have to read it, and a slot is free when that mask is
// zero. An allocate beat (op=0) picks the first free slot of the worker's ring in
// circular order from the worker's next pointer, loads its mask from reader_mask
// (bits at STAGES and above dropped), advances the pointer and returns found=1 with
// the slot; with no free slot it returns found=0, granted_slot=0 and changes nothing.
// A mark-read beat (op=1) clears one stage bit of one slot and returns found=1, or
// found=0 when worker, slot or stage is out of range. Exactly one result beat per
// input beat, in order. One item is taken at a time: the block reads the ring row
// and the slot mask from the synchronous RAMs, then searches and writes back; the
// write lands before the next item's read, so no forwarding is needed.
// A result waiting on out_stall does not block accepting the next item, but that
// item's write-back cycle waits until the output register drains.
// After reset the ring store is swept clean, one worker row per cycle, and in_stall
// stays high until the last row is cleared. The mask store is not cleared: a slot
// whose busy bit in the ring row is clear reads as an all-zero mask.
module stage_release_chunk_allocator #(
	parameter int WORKERS    = 8,
	parameter int POOL_SLOTS = 64,
	parameter int STAGES     = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [2:0]  worker,
	input  logic [5:0]  slot,
	input  logic [5:0]  stage,
	input  logic [63:0] reader_mask,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [5:0]  granted_slot
);

	localparam int WW    = (WORKERS > 1) ? $clog2(WORKERS) : 1;
	localparam int SW    = $clog2(POOL_SLOTS);
	localparam int XW    = (WW > 3) ? WW : 3;
	localparam int SX    = (SW > srca_pkg::SLOT_FIELD_W) ? SW : srca_pkg::SLOT_FIELD_W;
	localparam int AW    = WW + SW;
	localparam int ROW_W = SW + POOL_SLOTS;

	typedef logic [STAGES-1:0] smask_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t            state_q;
	logic [WW-1:0]     clr_q;

	// item held through the write-back cycle
	srca_pkg::op_t     op_q;
	logic              worker_ok_q;
	logic              mark_ok_q;
	logic [WW-1:0]     widx_q;
	logic [SW-1:0]     sidx_q;
	logic [5:0]        stage_q;
	smask_t            rmask_q;

	logic              out_valid_q;
	logic              found_q;
	logic [5:0]        granted_q;

	logic [XW-1:0]     worker_x;
	logic [SX-1:0]     slot_x;
	logic              accept;
	logic              exec_go;

	logic [ROW_W-1:0]  row_rd;
	logic [ROW_W-1:0]  row_wr;
	logic              row_we;
	logic [WW-1:0]     row_waddr;
	logic [POOL_SLOTS-1:0] busy;
	logic [POOL_SLOTS-1:0] busy_wr;
	logic [SW-1:0]     ptr;
	logic [SW-1:0]     ptr_wr;

	smask_t            mask_rd;
	smask_t            mask_wr;
	logic              mask_we;
	logic [SW-1:0]     sel;

	logic              hit;
	logic [SW-1:0]     hit_idx;
	logic [SW-1:0]     hit_next;
	logic              res_found;
	logic [SX-1:0]     res_slot_x;

	assign worker_x = XW'(worker);
	assign slot_x   = SX'(slot);
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	// write-back only when the output register can take the result
	assign exec_go  = (state_q == ST_EXEC) && !(out_valid_q && out_stall);

	assign busy = row_rd[POOL_SLOTS-1:0];
	assign ptr  = row_rd[ROW_W-1:POOL_SLOTS];

	srca_search #(
		.POOL_SLOTS(POOL_SLOTS)
	) u_search (
		.busy     (busy),
		.start    (ptr),
		.hit      (hit),
		.idx      (hit_idx),
		.idx_next (hit_next)
	);

	// write-back datapath
	always_comb begin
		sel       = (op_q == srca_pkg::OP_MARK) ? sidx_q : hit_idx;
		res_found = worker_ok_q && ((op_q == srca_pkg::OP_MARK) ? mark_ok_q : hit);
		if (op_q == srca_pkg::OP_MARK) begin
			// entry not marked busy holds stale data: treat as zero
			mask_wr = (busy[sel] ? mask_rd : '0) & ~(smask_t'(1) << stage_q);
			ptr_wr  = ptr;
		end else begin
			mask_wr = rmask_q;
			ptr_wr  = hit_next;
		end
		busy_wr      = busy;
		busy_wr[sel] = |mask_wr;
		mask_we      = exec_go && res_found;
		res_slot_x   = (res_found && (op_q == srca_pkg::OP_ALLOC)) ? SX'(hit_idx) : '0;
	end

	// ring store: cleared row by row after reset, else written back on update
	always_comb begin
		if (state_q == ST_CLEAR) begin
			row_we    = 1'b1;
			row_waddr = clr_q;
			row_wr    = '0;
		end else begin
			row_we    = mask_we;
			row_waddr = widx_q;
			row_wr    = {ptr_wr, busy_wr};
		end
	end

	srca_ram #(
		.ADDR_W(WW),
		.DATA_W(ROW_W)
	) u_ring_mem (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata (row_wr),
		.re    (accept),
		.raddr (worker_x[WW-1:0]),
		.rdata (row_rd)
	);

	srca_ram #(
		.ADDR_W(AW),
		.DATA_W(STAGES)
	) u_mask_mem (
		.clk   (clk),
		.we    (mask_we),
		.waddr ({widx_q, sel}),
		.wdata (mask_wr),
		.re    (accept),
		.raddr ({worker_x[WW-1:0], slot_x[SW-1:0]}),
		.rdata (mask_rd)
	);

	// control and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			granted_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + WW'(1);
					if (clr_q == WW'(WORKERS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
			if (exec_go) begin
				out_valid_q <= 1'b1;
				found_q     <= res_found;
				granted_q   <= res_slot_x[5:0];
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= srca_pkg::op_t'(op);
			worker_ok_q <= (32'(worker) < WORKERS);
			mark_ok_q   <= (32'(slot) < POOL_SLOTS) && (32'(stage) < STAGES);
			widx_q      <= worker_x[WW-1:0];
			sidx_q      <= slot_x[SW-1:0];
			stage_q     <= stage;
			rmask_q     <= reader_mask[STAGES-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign granted_slot = granted_q;

endmodule

/* hdl/srca_check.sv */
// Port-level checker for the stage release chunk allocator, plus its bind.
// Uses srca_pkg; sees only the top-level ports.
module srca_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        op,
	input logic [2:0]  worker,
	input logic [5:0]  slot,
	input logic [5:0]  stage,
	input logic [63:0] reader_mask,
	input logic        out_valid,
	input logic        out_stall,
	input logic        found,
	input logic [5:0]  granted_slot
);

	// a result beat held by out_stall keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) && $stable(granted_slot))
		else $error("result beat changed while stalled");

	// one item in flight: the beat after an accept is stalled
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item accepted while one is in flight");

	// with the output empty, the result is registered at the end of the accepted item's execute state
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |-> ##2 out_valid)
		else $error("result beat late");

	// mark-read never grants a slot
	a_mark_slot: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid && (op == srca_pkg::OP_MARK)
		|-> ##2 (granted_slot == 6'd0))
		else $error("mark-read result carries a slot");

	// a miss reports slot zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> granted_slot == 6'd0)
		else $error("miss with nonzero slot");

endmodule

bind stage_release_chunk_allocator srca_check u_srca_check (.*);
